// ===== rtl/ssfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfc_pkg
// Shared types, codes and tables of the seven-segment frame composer.
// ----------------------------------------------------------------------------

package ssfc_pkg;

	localparam int unsigned PATH_STEPS = 10;
	localparam int unsigned DIGITS     = 3;

	localparam logic       OP_NUMBER   = 1'b0;
	localparam logic       OP_PROGRESS = 1'b1;

	localparam logic [1:0] UNIT_PERCENT = 2'd1;
	localparam logic [1:0] UNIT_GRAM    = 2'd2;

	localparam logic [6:0] ICON_PERCENT = 7'h08;
	localparam logic [6:0] ICON_GRAM    = 7'h10;
	localparam logic [6:0] SEG_MID      = 7'h40;
	localparam logic [9:0] SAT_VALUE    = 10'd999;

	typedef logic [6:0] seg_t;
	typedef seg_t [DIGITS-1:0] digits_t;

	typedef struct packed {
		seg_t       hundreds;
		seg_t       tens;
		seg_t       ones;
		logic [6:0] icons_a;
		logic [2:0] icons_b;
	} frame_t;

	// fill path: digit position (0 hundreds, 1 tens, 2 ones) and segment
	localparam logic [1:0] PATH_POS [PATH_STEPS] = '{
		2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0
	};
	localparam seg_t PATH_SEG [PATH_STEPS] = '{
		7'h01, 7'h01, 7'h01, 7'h02, 7'h04, 7'h08, 7'h08, 7'h08, 7'h10, 7'h20
	};

	function automatic seg_t font(input logic [3:0] d);
		seg_t s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/ssfc_number.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfc_number
// Number frame: saturating decimal split, digit font, blanking and icons.
// ----------------------------------------------------------------------------

module ssfc_number (
	input  logic            digits_on,
	input  logic [15:0]     value,
	input  logic [1:0]      unit,
	input  logic [9:0]      icon_bits,
	output ssfc_pkg::frame_t frame
);

	logic [9:0]  sat;
	logic [15:0] hund_prod;
	logic [3:0]  hund;
	logic [9:0]  rem_h;
	logic [6:0]  rem_t;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [6:0]  ones_full;
	logic [3:0]  ones;
	logic [6:0]  unit_icon;

	// divide by 100 and by 10 through reciprocal multiplies, exact for this range
	always_comb begin
		sat       = (value > 16'(ssfc_pkg::SAT_VALUE)) ? ssfc_pkg::SAT_VALUE : value[9:0];
		hund_prod = 16'(sat) * 16'd41;
		hund      = hund_prod[15:12];
		rem_h     = sat - (10'(hund) * 10'd100);
		rem_t     = rem_h[6:0];
		tens_prod = 15'(rem_t) * 15'd205;
		tens      = tens_prod[14:11];
		ones_full = rem_t - (7'(tens) * 7'd10);
		ones      = ones_full[3:0];
	end

	always_comb begin
		case (unit)
			ssfc_pkg::UNIT_PERCENT: unit_icon = ssfc_pkg::ICON_PERCENT;
			ssfc_pkg::UNIT_GRAM:    unit_icon = ssfc_pkg::ICON_GRAM;
			default:                unit_icon = 7'h00;
		endcase
	end

	always_comb begin
		frame.hundreds = '0;
		frame.tens     = '0;
		frame.ones     = '0;
		if (digits_on) begin
			frame.hundreds = (sat >= 10'd100) ? ssfc_pkg::font(hund) : 7'h00;
			frame.tens     = (sat >= 10'd10) ? ssfc_pkg::font(tens) : 7'h00;
			frame.ones     = ssfc_pkg::font(ones);
		end
		frame.icons_a = icon_bits[6:0] | unit_icon;
		frame.icons_b = {icon_bits[7], icon_bits[9], icon_bits[8]};
	end

endmodule

// ===== rtl/ssfc_progress.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfc_progress
// Progress frame: lights the fill path up to ceil(pct/10) steps, max ten.
// ----------------------------------------------------------------------------

module ssfc_progress (
	input  logic             [7:0] progress_pct,
	input  logic                   middle_bars_on,
	output ssfc_pkg::frame_t       frame
);

	ssfc_pkg::digits_t g;

	// step i is lit when pct exceeds 10*i
	always_comb begin
		g = '0;
		for (int i = 0; i < ssfc_pkg::PATH_STEPS; i++) begin
			if (progress_pct > 8'(10 * i)) begin
				g[ssfc_pkg::PATH_POS[i]] = g[ssfc_pkg::PATH_POS[i]] | ssfc_pkg::PATH_SEG[i];
			end
		end
		if (middle_bars_on) begin
			for (int j = 0; j < ssfc_pkg::DIGITS; j++) begin
				g[j] = g[j] | ssfc_pkg::SEG_MID;
			end
		end
		frame.hundreds = g[0];
		frame.tens     = g[1];
		frame.ones     = g[2];
		frame.icons_a  = '0;
		frame.icons_b  = '0;
	end

endmodule

// ===== rtl/seven_segment_frame_composer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_frame_composer
// Builds one five-field display frame per command, number or progress mode.
// ----------------------------------------------------------------------------
// usage
// - command channel: a beat is taken at a rising edge with start high and
//   busy low; busy is always low, so a command may be given every cycle
// - result channel: done is high for exactly one cycle while the grid_*
//   ports hold the frame; the receiver takes it at the edge ending that cycle
// - path: a taken command is held in the input register, and its frame is then
//   stored in the result register, whose valid flag drives done
// - throughput: one frame per cycle, set by the input register and the
//   result register around a single pass of decode logic
// - number mode divides by 100 and 10 with constant reciprocal multiplies
//   inside that one pass
// - reset (arst_n low) clears the stage valid flags at once; no frame is
//   reported until a new command arrives
// - the receiver cannot stall; every frame is shown once for one cycle
// ----------------------------------------------------------------------------

module seven_segment_frame_composer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic        digits_on,
	input  logic [15:0] value,
	input  logic [1:0]  unit,
	input  logic [9:0]  icon_bits,
	input  logic [7:0]  progress_pct,
	input  logic        middle_bars_on,
	output logic        done,
	output logic [6:0]  grid_hundreds,
	output logic [6:0]  grid_tens,
	output logic [6:0]  grid_ones,
	output logic [6:0]  grid_icons_a,
	output logic [2:0]  grid_icons_b
);

	logic        valid_s1;
	logic        op_s1;
	logic        digits_on_s1;
	logic [15:0] value_s1;
	logic [1:0]  unit_s1;
	logic [9:0]  icon_bits_s1;
	logic [7:0]  progress_pct_s1;
	logic        middle_bars_on_s1;

	logic             valid_s2;
	ssfc_pkg::frame_t frame_s2;

	ssfc_pkg::frame_t num_frame;
	ssfc_pkg::frame_t prog_frame;
	ssfc_pkg::frame_t frame_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1             <= op;
			digits_on_s1      <= digits_on;
			value_s1          <= value;
			unit_s1           <= unit;
			icon_bits_s1      <= icon_bits;
			progress_pct_s1   <= progress_pct;
			middle_bars_on_s1 <= middle_bars_on;
		end
		if (valid_s1) begin
			frame_s2 <= frame_d;
		end
	end

	ssfc_number u_number (
		.digits_on   (digits_on_s1),
		.value       (value_s1),
		.unit        (unit_s1),
		.icon_bits   (icon_bits_s1),
		.frame       (num_frame)
	);

	ssfc_progress u_progress (
		.progress_pct   (progress_pct_s1),
		.middle_bars_on (middle_bars_on_s1),
		.frame          (prog_frame)
	);

	always_comb begin
		case (op_s1)
			ssfc_pkg::OP_PROGRESS: frame_d = prog_frame;
			default:               frame_d = num_frame;
		endcase
	end

	assign done          = valid_s2;
	assign grid_hundreds = frame_s2.hundreds;
	assign grid_tens     = frame_s2.tens;
	assign grid_ones     = frame_s2.ones;
	assign grid_icons_a  = frame_s2.icons_a;
	assign grid_icons_b  = frame_s2.icons_b;

`ifndef NO_ASSERTIONS
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> valid_s1)
		else $error("accepted beat did not reach stage one");

	a_s1_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("stage one beat did not produce a result");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a beat in stage one");

	a_progress_icons: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && op_s1 == ssfc_pkg::OP_PROGRESS |=> grid_icons_a == 7'h00
			&& grid_icons_b == 3'h0)
		else $error("icons lit in progress frame");

	a_blank_digits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && op_s1 == ssfc_pkg::OP_NUMBER && !digits_on_s1 |=>
			grid_hundreds == 7'h00 && grid_tens == 7'h00 && grid_ones == 7'h00)
		else $error("digits lit while blanked");

	a_ones_shown: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && op_s1 == ssfc_pkg::OP_NUMBER && digits_on_s1 |=>
			grid_ones != 7'h00)
		else $error("ones digit blank in number frame");
`endif

endmodule
